>>> rtl/core/pls_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int CAPACITY_DEF = 32;

	// Request kinds
	typedef enum logic [2:0] {
		REQ_INS_END   = 3'd0,
		REQ_INS_FRONT = 3'd1,
		REQ_INS_POS   = 3'd2,
		REQ_READ      = 3'd3,
		REQ_UPDATE    = 3'd4,
		REQ_DEL_FRONT = 3'd5,
		REQ_DEL_END   = 3'd6,
		REQ_DEL_POS   = 3'd7
	} req_kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_RANGE   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	// What a memory read is for
	typedef enum logic [1:0] {
		RD_NONE,
		RD_INS,
		RD_DEL,
		RD_LIST
	} rd_mode_t;

	// Index counter operations
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_FROM_CNT,
		IDX_ZERO,
		IDX_ONE,
		IDX_FROM_POS,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	// Target index selection
	typedef enum logic [1:0] {
		TGT_HOLD,
		TGT_ZERO,
		TGT_COUNT,
		TGT_POS
	} tgt_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load_req;
		tgt_sel_t tgt_sel;
		idx_op_t  idx_op;
		rd_mode_t rd_mode;
		logic     wr_val;
		logic     wr_at_pos;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     emit_status;
		status_t  status;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		req_kind_t kind;
		logic      cnt_zero;
		logic      cnt_full;
		logic      pos_zero;
		logic      pos_gt_cnt;
		logic      pos_gt_cnt1;
		logic      idx_gt_tgt;
		logic      idx_lt_cnt;
		logic      idx_last;
	} dp_stat_t;

endpackage

>>> rtl/core/pls_datapath.sv
// Datapath: request registers, element memory, count, index walk and result register.
`timescale 1ns / 1ps

module pls_datapath #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [2:0]                       req_type,
	input  logic [pls_pkg::POS_W-1:0]        position,
	input  logic signed [pls_pkg::DATA_W-1:0] value,
	input  pls_pkg::dp_cmd_t                 cmd,
	output pls_pkg::dp_stat_t                stat,
	output logic                             strobe,
	output logic [2:0]                       status,
	output logic signed [pls_pkg::DATA_W-1:0] element,
	output logic                             is_element,
	output logic                             last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W) + 1;

	logic [pls_pkg::DATA_W-1:0] mem [CAPACITY];

	pls_pkg::req_kind_t         kind_q;
	logic [pls_pkg::POS_W-1:0]  pos_q;
	logic [pls_pkg::DATA_W-1:0] val_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           idx_q;
	logic [IDX_W-1:0]           tgt_q;

	pls_pkg::rd_mode_t          rd_mode_s1;
	logic [IDX_W-1:0]           wr_addr_s1;
	logic                       last_s1;
	logic [pls_pkg::DATA_W-1:0] rdata_s1;

	logic [IDX_W-1:0]           pos_m1;
	logic [IDX_W-1:0]           rd_addr;
	logic [IDX_W-1:0]           shift_wr_addr;
	logic [CMP_W-1:0]           pos_ext;
	logic [CMP_W-1:0]           cnt_ext;
	logic [CNT_W-1:0]           idx_m1;

	// Compare helpers
	assign pos_m1  = IDX_W'(pos_q - pls_pkg::POS_W'(1));
	assign idx_m1  = idx_q - CNT_W'(1);
	assign pos_ext = CMP_W'(pos_q);
	assign cnt_ext = CMP_W'(count_q);

	// Status back to the controller
	always_comb begin
		stat.kind        = kind_q;
		stat.cnt_zero    = (count_q == '0);
		stat.cnt_full    = (count_q >= CNT_W'(CAPACITY));
		stat.pos_zero    = (pos_q == '0);
		stat.pos_gt_cnt  = (pos_ext > cnt_ext);
		stat.pos_gt_cnt1 = (pos_ext > cnt_ext + CMP_W'(1));
		stat.idx_gt_tgt  = (idx_q > CNT_W'(tgt_q));
		stat.idx_lt_cnt  = (idx_q < count_q);
		stat.idx_last    = (idx_q == count_q - CNT_W'(1));
	end

	// Read address and the write address of a shift step
	always_comb begin
		case (cmd.rd_mode)
			pls_pkg::RD_INS: begin
				rd_addr       = idx_m1[IDX_W-1:0];
				shift_wr_addr = idx_q[IDX_W-1:0];
			end
			pls_pkg::RD_DEL: begin
				rd_addr       = idx_q[IDX_W-1:0];
				shift_wr_addr = idx_m1[IDX_W-1:0];
			end
			default: begin
				rd_addr       = idx_q[IDX_W-1:0];
				shift_wr_addr = idx_q[IDX_W-1:0];
			end
		endcase
	end

	// Request registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= pls_pkg::req_kind_t'(req_type);
			pos_q  <= position;
			val_q  <= value;
		end
	end

	// Target index
	always_ff @(posedge clk) begin
		case (cmd.tgt_sel)
			pls_pkg::TGT_ZERO:  tgt_q <= '0;
			pls_pkg::TGT_COUNT: tgt_q <= count_q[IDX_W-1:0];
			pls_pkg::TGT_POS:   tgt_q <= pos_m1;
			default:            tgt_q <= tgt_q;
		endcase
	end

	// Element count and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.cnt_inc)
				count_q <= count_q + CNT_W'(1);
			else if (cmd.cnt_dec)
				count_q <= count_q - CNT_W'(1);
			case (cmd.idx_op)
				pls_pkg::IDX_FROM_CNT: idx_q <= count_q;
				pls_pkg::IDX_ZERO:     idx_q <= '0;
				pls_pkg::IDX_ONE:      idx_q <= CNT_W'(1);
				pls_pkg::IDX_FROM_POS: idx_q <= CNT_W'(pos_q);
				pls_pkg::IDX_INC:      idx_q <= idx_q + CNT_W'(1);
				pls_pkg::IDX_DEC:      idx_q <= idx_m1;
				default:               idx_q <= idx_q;
			endcase
		end
	end

	// Read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_mode_s1 <= pls_pkg::RD_NONE;
		end else begin
			rd_mode_s1 <= cmd.rd_mode;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= shift_wr_addr;
		last_s1    <= stat.idx_last;
	end

	// Element memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr];
		if (rd_mode_s1 == pls_pkg::RD_INS || rd_mode_s1 == pls_pkg::RD_DEL)
			mem[wr_addr_s1] <= rdata_s1;
		else if (cmd.wr_val)
			mem[cmd.wr_at_pos ? pos_m1 : tgt_q] <= val_q;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit_status || (rd_mode_s1 == pls_pkg::RD_LIST);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_mode_s1 == pls_pkg::RD_LIST) begin
			status     <= pls_pkg::ST_OK;
			element    <= rdata_s1;
			is_element <= 1'b1;
			last       <= last_s1;
		end else if (cmd.emit_status) begin
			status     <= cmd.status;
			element    <= '0;
			is_element <= 1'b0;
			last       <= 1'b1;
		end
	end

endmodule

>>> rtl/core/pls_ctrl.sv
// Controller: request checks and the sequencing of shifts and list reads.
`timescale 1ns / 1ps

module pls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pls_pkg::dp_stat_t stat,
	output pls_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_INS_SHIFT,
		S_INS_PUT,
		S_DEL_SHIFT,
		S_RD_LIST
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		cmd.load_req    = 1'b0;
		cmd.tgt_sel     = pls_pkg::TGT_HOLD;
		cmd.idx_op      = pls_pkg::IDX_HOLD;
		cmd.rd_mode     = pls_pkg::RD_NONE;
		cmd.wr_val      = 1'b0;
		cmd.wr_at_pos   = 1'b0;
		cmd.cnt_inc     = 1'b0;
		cmd.cnt_dec     = 1'b0;
		cmd.emit_status = 1'b0;
		cmd.status      = pls_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_IDLE;
				case (stat.kind)
					pls_pkg::REQ_INS_END, pls_pkg::REQ_INS_FRONT: begin
						if (stat.cnt_full) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_FULL;
						end else begin
							cmd.tgt_sel = (stat.kind == pls_pkg::REQ_INS_END) ?
								pls_pkg::TGT_COUNT : pls_pkg::TGT_ZERO;
							cmd.idx_op  = pls_pkg::IDX_FROM_CNT;
							state_d     = S_INS_SHIFT;
						end
					end
					pls_pkg::REQ_INS_POS: begin
						if (stat.pos_zero) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_INVALID;
						end else if (stat.pos_gt_cnt1) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_RANGE;
						end else if (stat.cnt_full) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_FULL;
						end else begin
							cmd.tgt_sel = pls_pkg::TGT_POS;
							cmd.idx_op  = pls_pkg::IDX_FROM_CNT;
							state_d     = S_INS_SHIFT;
						end
					end
					pls_pkg::REQ_READ: begin
						if (stat.cnt_zero) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_EMPTY;
						end else begin
							cmd.idx_op = pls_pkg::IDX_ZERO;
							state_d    = S_RD_LIST;
						end
					end
					pls_pkg::REQ_UPDATE: begin
						cmd.emit_status = 1'b1;
						if (stat.cnt_zero)
							cmd.status = pls_pkg::ST_EMPTY;
						else if (stat.pos_zero)
							cmd.status = pls_pkg::ST_INVALID;
						else if (stat.pos_gt_cnt)
							cmd.status = pls_pkg::ST_RANGE;
						else begin
							cmd.wr_val    = 1'b1;
							cmd.wr_at_pos = 1'b1;
						end
					end
					pls_pkg::REQ_DEL_FRONT: begin
						if (stat.cnt_zero) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_EMPTY;
						end else begin
							cmd.idx_op = pls_pkg::IDX_ONE;
							state_d    = S_DEL_SHIFT;
						end
					end
					pls_pkg::REQ_DEL_END: begin
						cmd.emit_status = 1'b1;
						if (stat.cnt_zero)
							cmd.status = pls_pkg::ST_EMPTY;
						else
							cmd.cnt_dec = 1'b1;
					end
					default: begin
						if (stat.pos_zero) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_INVALID;
						end else if (stat.cnt_zero) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_EMPTY;
						end else if (stat.pos_gt_cnt) begin
							cmd.emit_status = 1'b1;
							cmd.status      = pls_pkg::ST_RANGE;
						end else begin
							cmd.idx_op = pls_pkg::IDX_FROM_POS;
							state_d    = S_DEL_SHIFT;
						end
					end
				endcase
			end
			// Move elements up one slot, top first; the last write lands on exit
			S_INS_SHIFT: begin
				if (stat.idx_gt_tgt) begin
					cmd.rd_mode = pls_pkg::RD_INS;
					cmd.idx_op  = pls_pkg::IDX_DEC;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				cmd.wr_val      = 1'b1;
				cmd.cnt_inc     = 1'b1;
				cmd.emit_status = 1'b1;
				state_d         = S_IDLE;
			end
			// Move elements down one slot, bottom first
			S_DEL_SHIFT: begin
				if (stat.idx_lt_cnt) begin
					cmd.rd_mode = pls_pkg::RD_DEL;
					cmd.idx_op  = pls_pkg::IDX_INC;
				end else begin
					cmd.cnt_dec     = 1'b1;
					cmd.emit_status = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_RD_LIST: begin
				cmd.rd_mode = pls_pkg::RD_LIST;
				cmd.idx_op  = pls_pkg::IDX_INC;
				if (stat.idx_last)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != S_IDLE);
		end
	end

endmodule

>>> rtl/core/positional_list_store.sv
// Top level of the positional list store: controller plus datapath.
// A rejected request, an update or a delete at end strobes its status straight from the check state.
// Inserts and deletes at index k shift the elements from k upward by one slot, busy throughout.
// A list read strobes one element per cycle, with no stall between elements.
// Shifts and list reads walk the element memory one slot at a time through its one read port.
// Reset clears the count and controller; memory contents stay undefined, no clearing pass.
// Results are single-cycle strobes; the receiver cannot stall them.
`timescale 1ns / 1ps

module positional_list_store #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        req_type,
	input  logic [pls_pkg::POS_W-1:0]         position,
	input  logic signed [pls_pkg::DATA_W-1:0] value,
	output logic                              strobe,
	output logic [2:0]                        status,
	output logic signed [pls_pkg::DATA_W-1:0] element,
	output logic                              is_element,
	output logic                              last
);

	pls_pkg::dp_cmd_t  cmd;
	pls_pkg::dp_stat_t stat;

	pls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	pls_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.position   (position),
		.value      (value),
		.cmd        (cmd),
		.stat       (stat),
		.strobe     (strobe),
		.status     (status),
		.element    (element),
		.is_element (is_element),
		.last       (last)
	);

endmodule

>>> rtl/core/pls_checker.sv
// Port-level checks on the positional list store, bound to the top level.
`timescale 1ns / 1ps

module pls_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              strobe,
	input logic [2:0]                        status,
	input logic signed [pls_pkg::DATA_W-1:0] element,
	input logic                              is_element,
	input logic                              last
);

	// List elements come out back to back until the last one
	a_list_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("list read result burst broken");

	// A status result is always the final one of its request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_element |-> last && element == '0)
		else $error("status result not final or element nonzero");

	// Element results always report ok
	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_element |-> status == pls_pkg::ST_OK)
		else $error("element result with non-ok status");

	// An accepted request keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without going busy");

endmodule

bind positional_list_store pls_checker u_pls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.status     (status),
	.element    (element),
	.is_element (is_element),
	.last       (last)
);

>>> verif/tb_positional_list_store.sv
// Self-checking testbench for the positional list store.
`timescale 1ns / 1ps

module tb_positional_list_store;

	localparam int CAPACITY      = pls_pkg::CAPACITY_DEF;
	localparam int RANDOM_ITEMS  = 146;
	localparam int STALL_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = CAPACITY + 8;
	localparam int N_DIRECTED    = 24;

	// One result as the block should present it
	typedef struct packed {
		pls_pkg::status_t   st;
		logic signed [31:0] elem;
		logic               is_elem;
		logic               fin;
	} list_result_t;

	// Directed request, with a hand-written status where it is obvious
	typedef struct packed {
		pls_pkg::req_kind_t kind;
		logic [7:0]         pos;
		logic signed [31:0] val;
		logic               typed;
		pls_pkg::status_t   want;
	} directed_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [2:0]                        req_type;
	logic [pls_pkg::POS_W-1:0]         position;
	logic signed [pls_pkg::DATA_W-1:0] value;
	logic                              strobe;
	logic [2:0]                        status;
	logic signed [pls_pkg::DATA_W-1:0] element;
	logic                              is_element;
	logic                              last;

	// Typed expectation travels along with the request
	logic                     typed_valid;
	pls_pkg::status_t         typed_status;

	// Shadow list and expected results
	logic signed [31:0] list_model [CAPACITY];
	int                 list_len;
	list_result_t       fresh_results[$];
	list_result_t       expected_results[$];
	list_result_t       got_exp;

	int  error_count;
	int  accepted_count;
	int  checked_count;
	int  full_visits;
	int  full_rejects;
	int  idle_cycles;
	int  no_idle_left;
	bit  growing;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{pls_pkg::REQ_READ,      8'd0,   32'sd0,         1'b1, pls_pkg::ST_EMPTY},
		'{pls_pkg::REQ_DEL_FRONT, 8'd0,   32'sd0,         1'b1, pls_pkg::ST_EMPTY},
		'{pls_pkg::REQ_DEL_END,   8'd0,   32'sd0,         1'b1, pls_pkg::ST_EMPTY},
		'{pls_pkg::REQ_UPDATE,    8'd1,   32'sd5,         1'b1, pls_pkg::ST_EMPTY},
		'{pls_pkg::REQ_DEL_POS,   8'd0,   32'sd0,         1'b1, pls_pkg::ST_INVALID},
		'{pls_pkg::REQ_DEL_POS,   8'd1,   32'sd0,         1'b1, pls_pkg::ST_EMPTY},
		'{pls_pkg::REQ_INS_POS,   8'd0,   32'sd9,         1'b1, pls_pkg::ST_INVALID},
		'{pls_pkg::REQ_INS_POS,   8'd2,   32'sd9,         1'b1, pls_pkg::ST_RANGE},
		'{pls_pkg::REQ_INS_POS,   8'd255, 32'sd9,         1'b1, pls_pkg::ST_RANGE},
		'{pls_pkg::REQ_INS_POS,   8'd1,   32'sh8000_0000, 1'b1, pls_pkg::ST_OK},
		'{pls_pkg::REQ_INS_END,   8'd0,   32'sh7fff_ffff, 1'b1, pls_pkg::ST_OK},
		'{pls_pkg::REQ_INS_FRONT, 8'd0,   32'shffff_ffff, 1'b1, pls_pkg::ST_OK},
		'{pls_pkg::REQ_INS_POS,   8'd4,   32'sd0,         1'b1, pls_pkg::ST_OK},
		'{pls_pkg::REQ_INS_POS,   8'd2,   32'sd12345,     1'b0, pls_pkg::ST_OK},
		'{pls_pkg::REQ_READ,      8'd0,   32'sd0,         1'b0, pls_pkg::ST_OK},
		'{pls_pkg::REQ_UPDATE,    8'd0,   32'sd1,         1'b1, pls_pkg::ST_INVALID},
		'{pls_pkg::REQ_UPDATE,    8'd6,   32'sd1,         1'b1, pls_pkg::ST_RANGE},
		'{pls_pkg::REQ_UPDATE,    8'd5,   32'sh5555_5555, 1'b1, pls_pkg::ST_OK},
		'{pls_pkg::REQ_DEL_POS,   8'd6,   32'sd0,         1'b1, pls_pkg::ST_RANGE},
		'{pls_pkg::REQ_DEL_POS,   8'd3,   32'sd0,         1'b0, pls_pkg::ST_OK},
		'{pls_pkg::REQ_DEL_FRONT, 8'd0,   32'sd0,         1'b0, pls_pkg::ST_OK},
		'{pls_pkg::REQ_DEL_END,   8'd0,   32'sd0,         1'b0, pls_pkg::ST_OK},
		'{pls_pkg::REQ_READ,      8'd0,   32'sd0,         1'b0, pls_pkg::ST_OK},
		'{pls_pkg::REQ_DEL_POS,   8'd255, 32'sd0,         1'b1, pls_pkg::ST_RANGE}
	};

	pls_pkg::req_kind_t grow_kinds   [3] = '{pls_pkg::REQ_INS_END, pls_pkg::REQ_INS_FRONT,
		pls_pkg::REQ_INS_POS};
	pls_pkg::req_kind_t shrink_kinds [3] = '{pls_pkg::REQ_DEL_FRONT, pls_pkg::REQ_DEL_END,
		pls_pkg::REQ_DEL_POS};
	logic signed [31:0] edge_values [4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1};

	positional_list_store #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.position  (position),
		.value     (value),
		.strobe    (strobe),
		.status    (status),
		.element   (element),
		.is_element(is_element),
		.last      (last)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	function automatic void push_status(pls_pkg::status_t st);
		fresh_results.push_back('{st, 32'sd0, 1'b0, 1'b1});
		if (st == pls_pkg::ST_FULL)
			full_rejects++;
	endfunction

	// Shift-based list model: updates the shadow list and queues the results
	function automatic void apply_request(pls_pkg::req_kind_t kind, logic [7:0] pos,
			logic signed [31:0] val);
		int idx;
		int i;
		fresh_results.delete();
		case (kind)
			pls_pkg::REQ_INS_END, pls_pkg::REQ_INS_FRONT, pls_pkg::REQ_INS_POS: begin
				if (kind == pls_pkg::REQ_INS_POS && pos == 0)
					push_status(pls_pkg::ST_INVALID);
				else if (kind == pls_pkg::REQ_INS_POS && int'(pos) > list_len + 1)
					push_status(pls_pkg::ST_RANGE);
				else if (list_len >= CAPACITY)
					push_status(pls_pkg::ST_FULL);
				else begin
					if (kind == pls_pkg::REQ_INS_END)
						idx = list_len;
					else if (kind == pls_pkg::REQ_INS_FRONT)
						idx = 0;
					else
						idx = int'(pos) - 1;
					for (i = list_len; i > idx; i--)
						list_model[i] = list_model[i-1];
					list_model[idx] = val;
					list_len++;
					if (list_len == CAPACITY)
						full_visits++;
					push_status(pls_pkg::ST_OK);
				end
			end
			pls_pkg::REQ_READ: begin
				if (list_len == 0)
					push_status(pls_pkg::ST_EMPTY);
				else begin
					for (i = 0; i < list_len; i++)
						fresh_results.push_back('{pls_pkg::ST_OK, list_model[i], 1'b1,
							i == list_len - 1});
				end
			end
			pls_pkg::REQ_UPDATE: begin
				if (list_len == 0)
					push_status(pls_pkg::ST_EMPTY);
				else if (pos == 0)
					push_status(pls_pkg::ST_INVALID);
				else if (int'(pos) > list_len)
					push_status(pls_pkg::ST_RANGE);
				else begin
					list_model[int'(pos)-1] = val;
					push_status(pls_pkg::ST_OK);
				end
			end
			default: begin
				// all three delete kinds
				if (kind == pls_pkg::REQ_DEL_POS && pos == 0)
					push_status(pls_pkg::ST_INVALID);
				else if (list_len == 0)
					push_status(pls_pkg::ST_EMPTY);
				else if (kind == pls_pkg::REQ_DEL_POS && int'(pos) > list_len)
					push_status(pls_pkg::ST_RANGE);
				else begin
					if (kind == pls_pkg::REQ_DEL_FRONT)
						idx = 0;
					else if (kind == pls_pkg::REQ_DEL_END)
						idx = list_len - 1;
					else
						idx = int'(pos) - 1;
					for (i = idx; i + 1 < list_len; i++)
						list_model[i] = list_model[i+1];
					list_len--;
					push_status(pls_pkg::ST_OK);
				end
			end
		endcase
	endfunction

	// Check results first, then predict for a request taken at this edge
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_results.size() == 0)
				report_mismatch("result with nothing pending", {29'd0, status}, 32'd0);
			else begin
				got_exp = expected_results.pop_front();
				checked_count++;
				if (status !== got_exp.st)
					report_mismatch("status", {29'd0, status}, {29'd0, got_exp.st});
				if (element !== got_exp.elem)
					report_mismatch("element", element, got_exp.elem);
				if (is_element !== got_exp.is_elem)
					report_mismatch("is_element", {31'd0, is_element},
						{31'd0, got_exp.is_elem});
				if (last !== got_exp.fin)
					report_mismatch("last", {31'd0, last}, {31'd0, got_exp.fin});
			end
		end
		if (arst_n && start && !busy) begin
			accepted_count++;
			apply_request(pls_pkg::req_kind_t'(req_type), position, value);
			if (typed_valid)
				expected_results.push_back('{typed_status, 32'sd0, 1'b0, 1'b1});
			else
				foreach (fresh_results[k])
					expected_results.push_back(fresh_results[k]);
		end
	end

	// Watchdog: no request or result for too long ends the run
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || strobe)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] timeout: %0d results still pending", $time, expected_results.size());
		$display("Test completed with failures");
		$finish;
	end

	// Drive one request after a random gap, hold it until taken
	task automatic send_request(pls_pkg::req_kind_t kind, logic [7:0] pos,
			logic signed [31:0] val, logic typed, pls_pkg::status_t want);
		int gap;
		if (no_idle_left > 0) begin
			gap = 0;
			no_idle_left--;
		end else if ($urandom_range(0, 15) == 0) begin
			gap = 0;
			no_idle_left = $urandom_range(5, 20);
		end else
			gap = $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        = 1'b1;
		req_type     = kind;
		position     = pos;
		value        = val;
		typed_valid  = typed;
		typed_status = want;
		do @(posedge clk); while (busy);
	endtask

	// Random request, steered to fill the list to capacity and drain it again
	task automatic send_random();
		pls_pkg::req_kind_t kind;
		logic [7:0]         pos;
		logic signed [31:0] val;
		int                 roll;
		int                 limit;
		if (list_len >= CAPACITY && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		if (list_len == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
		roll = $urandom_range(0, 99);
		if (roll < 68)
			kind = growing ? grow_kinds[$urandom_range(0, 2)] :
				shrink_kinds[$urandom_range(0, 2)];
		else if (roll < 82)
			kind = pls_pkg::REQ_UPDATE;
		else if (roll < 90)
			kind = pls_pkg::REQ_READ;
		else
			kind = pls_pkg::req_kind_t'($urandom_range(0, 7));
		// mostly legal positions, with zero, just-past-end and wild ones mixed in
		limit = (kind == pls_pkg::REQ_INS_POS) ? list_len + 1 : list_len;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			pos = 8'($urandom_range(1, (limit < 1) ? 1 : limit));
		else if (roll == 7)
			pos = 8'd0;
		else if (roll == 8)
			pos = 8'(limit + 1);
		else
			pos = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 7) == 0)
			val = edge_values[$urandom_range(0, 3)];
		else
			val = $urandom();
		send_request(kind, pos, val, 1'b0, pls_pkg::ST_OK);
	endtask

	// Main sequence
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = pls_pkg::REQ_INS_END;
		position     = '0;
		value        = '0;
		typed_valid  = 1'b0;
		typed_status = pls_pkg::ST_OK;
		list_len     = 0;
		error_count  = 0;
		accepted_count = 0;
		checked_count  = 0;
		full_visits  = 0;
		full_rejects = 0;
		no_idle_left = 0;
		growing      = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		foreach (directed_rows[r])
			send_request(directed_rows[r].kind, directed_rows[r].pos, directed_rows[r].val,
				directed_rows[r].typed, directed_rows[r].want);

		// random part
		repeat (RANDOM_ITEMS)
			send_random();
		@(negedge clk);
		start = 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests and checked %0d results.", accepted_count, checked_count);
		$display("List reached capacity %0d times; %0d inserts were refused as full.",
			full_visits, full_rejects);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
